// File: rtl/cxpd_pkg.sv
// ---------------------------------------------------------------------------
// cxpd_pkg
// Shared types and constants for the chained XOR PackBits decoder.
// ---------------------------------------------------------------------------
package cxpd_pkg;

   // Input operation codes.
   localparam logic OP_RESTART = 1'b0;
   localparam logic OP_DATA    = 1'b1;

   // PackBits header boundary and run length base.
   localparam logic [8:0] RUN_BASE = 9'd257;

   // Decoder phase, one-hot.
   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_LITERAL = 3'b010,
      PH_RUN     = 3'b100
   } phase_type;

   // Contents of the input register.
   typedef struct packed {
      logic       valid;
      logic       operation;
      logic [7:0] data_byte;
   } stage_type;

endpackage

// File: rtl/cxpd_req_if.sv
// ---------------------------------------------------------------------------
// cxpd_req_if
// Request channel: one operation and one stream byte per beat.
// ---------------------------------------------------------------------------
interface cxpd_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] data_byte;

   modport source (output valid, output operation, output data_byte, input ready);
   modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

// File: rtl/cxpd_rsp_if.sv
// ---------------------------------------------------------------------------
// cxpd_rsp_if
// Response channel: one decoded byte and its repeat count per beat.
// ---------------------------------------------------------------------------
interface cxpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [7:0] repeat_count;

   modport source (output valid, output out_byte, output repeat_count, input ready);
   modport sink   (input valid, input out_byte, input repeat_count, output ready);
endinterface

// File: rtl/cxpd_input_stage.sv
// ---------------------------------------------------------------------------
// cxpd_input_stage
// Input register that captures one request beat and holds it until the
// decoder consumes it.
// ---------------------------------------------------------------------------
module cxpd_input_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic                in_operation,
   input  logic [7:0]          in_data_byte,
   output logic                in_ready,
   input  logic                advance,
   output cxpd_pkg::stage_type stage
);

   cxpd_pkg::stage_type stage_ff, stage_in;

   // The register is free when empty or when its item leaves this cycle.
   assign in_ready = !stage_ff.valid || advance;

   // Next contents of the register.
   always_comb begin
      stage_in = stage_ff;
      if (in_ready) begin
         stage_in.valid     = in_valid;
         stage_in.operation = in_operation;
         stage_in.data_byte = in_data_byte;
      end
   end

   // Only the valid bit needs a reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.operation <= stage_in.operation;
      stage_ff.data_byte <= stage_in.data_byte;
   end

   assign stage = stage_ff;

endmodule

// File: rtl/cxpd_unscramble.sv
// ---------------------------------------------------------------------------
// cxpd_unscramble
// Chained XOR unscrambler with bypass register and chain byte.
// ---------------------------------------------------------------------------
module cxpd_unscramble (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic                csr_write_data,
   input  cxpd_pkg::stage_type stage,
   input  logic                advance,
   output logic [7:0]          plain_byte
);

   logic       decrypt_enable_ff;
   logic [7:0] chain_ff, chain_in;

   // The chain follows the ciphertext on every consumed beat, also in
   // bypass, and a restart loads the seed the same way.
   assign chain_in = advance ? stage.data_byte : chain_ff;

   assign plain_byte = decrypt_enable_ff ? (stage.data_byte ^ chain_ff) : stage.data_byte;

   // Configuration register and chain byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         decrypt_enable_ff <= 1'b1;
         chain_ff          <= 8'd0;
      end else begin
         if (csr_write_enable) begin
            decrypt_enable_ff <= csr_write_data;
         end
         chain_ff <= chain_in;
      end
   end

endmodule

// File: rtl/cxpd_rle_decode.sv
// ---------------------------------------------------------------------------
// cxpd_rle_decode
// PackBits phase tracking and the registered response beat.
// ---------------------------------------------------------------------------
module cxpd_rle_decode (
   input  logic                clock,
   input  logic                reset,
   input  cxpd_pkg::stage_type stage,
   input  logic [7:0]          plain_byte,
   output logic                advance,
   cxpd_rsp_if.source          rsp_chan
);

   cxpd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          out_byte_ff, out_byte_in;
   logic [7:0]          repeat_ff, repeat_in;
   logic                is_data;
   logic                needs_out;
   logic                out_free;
   logic                load;
   logic [7:0]          count_dec;

   assign is_data   = stage.valid && (stage.operation == cxpd_pkg::OP_DATA);
   assign needs_out = is_data &&
                      ((phase_ff == cxpd_pkg::PH_LITERAL) || (phase_ff == cxpd_pkg::PH_RUN));
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign advance   = stage.valid && (!needs_out || out_free);
   assign load      = advance && needs_out;
   assign count_dec = count_ff - 8'd1;

   // Phase and count update for the consumed beat.
   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      out_byte_in = out_byte_ff;
      repeat_in   = repeat_ff;
      if (advance) begin
         if (stage.operation == cxpd_pkg::OP_RESTART) begin
            phase_in = cxpd_pkg::PH_HEADER;
            count_in = 8'd0;
         end else begin
            case (phase_ff)
               cxpd_pkg::PH_LITERAL: begin
                  out_byte_in = plain_byte;
                  repeat_in   = 8'd1;
                  count_in    = count_dec;
                  if (count_dec == 8'd0) begin
                     phase_in = cxpd_pkg::PH_HEADER;
                  end
               end
               cxpd_pkg::PH_RUN: begin
                  out_byte_in = plain_byte;
                  repeat_in   = count_ff;
                  count_in    = 8'd0;
                  phase_in    = cxpd_pkg::PH_HEADER;
               end
               default: begin
                  // Header byte: the top bit picks a run or a literal group.
                  if (plain_byte[7]) begin
                     count_in = 8'(cxpd_pkg::RUN_BASE - {1'b0, plain_byte});
                     phase_in = cxpd_pkg::PH_RUN;
                  end else begin
                     count_in = plain_byte + 8'd1;
                     phase_in = cxpd_pkg::PH_LITERAL;
                  end
               end
            endcase
         end
      end
   end

   // The response beat stays until taken; a new one loads only when free.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= cxpd_pkg::PH_HEADER;
         count_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_byte_ff <= out_byte_in;
      repeat_ff   <= repeat_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_byte     = out_byte_ff;
   assign rsp_chan.repeat_count = repeat_ff;

endmodule

// File: rtl/chained_xor_packbits_decoder_unit.sv
// ---------------------------------------------------------------------------
// chained_xor_packbits_decoder_unit
// Chained XOR unscrambler followed by a PackBits run-length decoder.
// ---------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  req_chan  in         operation (restart / data), data_byte
//  rsp_chan  out        out_byte, repeat_count (1 to 129)
//  csr_*     in         decrypt_enable write, no read-back
//
// One request beat is taken every cycle while the response channel does not
// stall; a byte that yields a response is held in the input register first
// and reaches rsp_chan at the edge that takes it out of that register.
// The rate is set by the single phase and count update of the decoder.
// Reset is synchronous and returns to expect-header with decryption on.
// A stalled response stops only beats that need a response slot; header
// and restart beats keep flowing past it.
// ---------------------------------------------------------------------------
module chained_xor_packbits_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   cxpd_req_if.sink   req_chan,
   cxpd_rsp_if.source rsp_chan,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);

   cxpd_pkg::stage_type stage;
   logic                advance;
   logic [7:0]          plain_byte;

   // Input register.
   cxpd_input_stage u_input_stage (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_chan.valid),
      .in_operation (req_chan.operation),
      .in_data_byte (req_chan.data_byte),
      .in_ready     (req_chan.ready),
      .advance      (advance),
      .stage        (stage)
   );

   // Unscrambler.
   cxpd_unscramble u_unscramble (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .stage            (stage),
      .advance          (advance),
      .plain_byte       (plain_byte)
   );

   // Run-length decoder and response register.
   cxpd_rle_decode u_rle_decode (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .plain_byte (plain_byte),
      .advance    (advance),
      .rsp_chan   (rsp_chan)
   );

   // A response always carries a legal repeat count.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.repeat_count != 8'd0) && (rsp_chan.repeat_count <= 8'd129))
      else $error("repeat count out of range");

   // An empty input register always takes a beat.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !stage.valid |-> req_chan.ready)
      else $error("input register empty but not ready");

   // A held item keeps its contents until the decoder consumes it.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (stage.valid && !advance) |=> (stage.valid && $stable(stage.data_byte)
                                     && $stable(stage.operation)))
      else $error("input register changed while held");

endmodule
